[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[design/lir_pkg.sv]
// Shared constants and types of the linear interpolation resampler.
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_UPSAMPLE = 8;

  localparam int SAMPLE_W  = SAMPLE_BITS;
  localparam int TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int RATE_W    = 18;
  localparam int POS_W     = 48;
  localparam int DIVN_W    = RATE_W + 1;
  localparam int FRAC_W    = 16;
  localparam int DIVQ_W    = DIVN_W + FRAC_W;
  localparam int DIVC_W    = $clog2(DIVQ_W + 1);
  localparam int GUARD_MAX = MAX_UPSAMPLE + 1;
  localparam int GUARD_W   = $clog2(GUARD_MAX + 1);
  localparam int UPS_W     = $clog2(MAX_UPSAMPLE + 1);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16000);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = CFG_IDX_W'(1);

  typedef struct packed {
    logic                pass;
    logic                fin;
    logic [SAMPLE_W-1:0] sample;
  } lir_item_t;

  typedef struct packed {
    logic [RATE_W-1:0] src;
    logic [RATE_W-1:0] dst;
  } lir_rates_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] init_rem;
    logic [DIVN_W-1:0] numer;
    logic [DIVC_W-1:0] steps;
    logic [RATE_W-1:0] divisor;
  } lir_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVQ_W-1:0] quot;
    logic [RATE_W-1:0] rem;
  } lir_div_rsp_t;

  typedef struct packed {
    logic               div_wait;
    logic [GUARD_W-1:0] guard;
  } lir_back_stat_t;

endpackage

`default_nettype wire

[design/linear_interp_resampler.sv]
// Top level of the linear interpolation sample rate converter.
// Passthrough request: queue, ST_IDLE, ST_EMIT, then the output register drives out_tvalid.
// Resampling: a blended output runs a fraction division (35 steps) and a phase division
// (19 steps) in the shared bit-serial divider; an output at the final sample runs only
// the phase division. A two-entry queue lets further requests run ahead of the sequencer.
// Reset (rst_n low, synchronous) sets both rates to 16000 and clears stream state.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lir_pkg::RATE_W-1:0]    cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [lir_pkg::TDATA_W-1:0]   in_tdata,   // [15:0] sample_in
  input  wire logic                          in_tlast,   // final_sample
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [lir_pkg::TDATA_W-1:0]        out_tdata,  // [15:0] sample_out
  output logic                               out_tlast   // final_output
);
  import lir_pkg::*;

  lir_item_t           push_item;
  lir_item_t           head_item;
  lir_rates_t          rates;
  lir_div_req_t        div_req;
  lir_div_rsp_t        div_rsp;
  lir_back_stat_t      back_stat;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [SAMPLE_W-1:0] out_data;

  lir_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .in_fin    (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item),
    .rates     (rates)
  );

  lir_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .item_in  (push_item),
    .pop      (q_pop),
    .item_out (head_item),
    .full     (q_full),
    .empty    (q_empty)
  );

  lir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lir_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rates     (rates),
    .q_empty   (q_empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data),
    .out_last  (out_tlast),
    .stat      (back_stat)
  );

  assign out_tdata = TDATA_W'(out_data);

`include "assert_macros.svh"

  `ASSERT_NEVER(a_div_start_busy, clk, rst_n, div_req.start && div_rsp.busy, "divider restarted while busy")
  `ASSERT_PROP(a_div_done_wait, clk, rst_n, div_rsp.done |-> back_stat.div_wait, "divider result not awaited")
  `ASSERT_NEVER(a_guard_bound, clk, rst_n, back_stat.guard > GUARD_W'(GUARD_MAX), "output guard overrun")

endmodule

`default_nettype wire

[design/lir_front.sv]
// Front end: rate registers, request classification and queue push.
`timescale 1ns / 1ps
`default_nettype none

module lir_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lir_pkg::RATE_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [lir_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                           in_fin,
  input  wire logic                           q_full,
  output logic                                q_push,
  output lir_pkg::lir_item_t                  q_item,
  output lir_pkg::lir_rates_t                 rates
);
  import lir_pkg::*;

  localparam int UPL_W = RATE_W + UPS_W;

  logic [RATE_W-1:0] src_r, src_nxt;
  logic [RATE_W-1:0] dst_r, dst_nxt;
  logic [UPL_W-1:0]  up_lim;
  logic              pass;

  always_comb begin
    src_nxt = src_r;
    dst_nxt = dst_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SOURCE_RATE: src_nxt = cfg_data;
        CFG_TARGET_RATE: dst_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= RATE_RESET;
      dst_r <= RATE_RESET;
    end else begin
      src_r <= src_nxt;
      dst_r <= dst_nxt;
    end
  end

  // upsampling bound on the effective target rate
  assign up_lim = {{UPS_W{1'b0}}, src_r} * UPL_W'(MAX_UPSAMPLE);
  assign rates.src = src_r;
  assign rates.dst = ({{UPS_W{1'b0}}, dst_r} > up_lim) ? up_lim[RATE_W-1:0] : dst_r;

  assign pass = (src_r == '0) || (dst_r == '0) || (src_r == dst_r);

  assign in_ready      = !q_full;
  assign q_push        = in_valid && !q_full;
  assign q_item.pass   = pass;
  assign q_item.fin    = in_fin;
  assign q_item.sample = in_sample;

endmodule

`default_nettype wire

[design/lir_queue.sv]
// Short request queue between the front end and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lir_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  lir_pkg::lir_item_t item_in,
  input  wire logic          pop,
  output lir_pkg::lir_item_t item_out,
  output logic               full,
  output logic               empty
);
  import lir_pkg::*;

  lir_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

[design/lir_div.sv]
// Bit-serial restoring divider shared by the fraction and phase steps.
`timescale 1ns / 1ps
`default_nettype none

module lir_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  lir_pkg::lir_div_req_t req,
  output lir_pkg::lir_div_rsp_t rsp
);
  import lir_pkg::*;

  logic [RATE_W-1:0] r_r, r_nxt;
  logic [DIVN_W-1:0] n_r, n_nxt;
  logic [DIVQ_W-1:0] q_r, q_nxt;
  logic [RATE_W-1:0] d_r, d_nxt;
  logic [DIVC_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   trial_sub;
  logic              take;

  // partial remainder stays below the divisor, so one bit more covers the trial
  assign trial     = {r_r, n_r[DIVN_W-1]};
  assign trial_sub = trial - {1'b0, d_r};
  assign take      = (trial >= {1'b0, d_r});

  always_comb begin
    r_nxt    = r_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      r_nxt    = req.init_rem;
      n_nxt    = req.numer;
      q_nxt    = '0;
      d_nxt    = req.divisor;
      cnt_nxt  = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = take ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
      q_nxt   = {q_r[DIVQ_W-2:0], take};
      n_nxt   = {n_r[DIVN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - DIVC_W'(1);
      if (cnt_r == DIVC_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    n_r <= n_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

`default_nettype wire

[design/lir_back.sv]
// Back end: phase accumulator sequencer, blend datapath and output register.
`timescale 1ns / 1ps
`default_nettype none

module lir_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  lir_pkg::lir_rates_t               rates,
  input  wire logic                         q_empty,
  input  lir_pkg::lir_item_t                q_item,
  output logic                              q_pop,
  output lir_pkg::lir_div_req_t             div_req,
  input  lir_pkg::lir_div_rsp_t             div_rsp,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lir_pkg::SAMPLE_W-1:0]      out_data,
  output logic                              out_last,
  output lir_pkg::lir_back_stat_t           stat
);
  import lir_pkg::*;

  localparam int PROD_W = SAMPLE_W + FRAC_W + 2;
  localparam int STEP_W = PROD_W - FRAC_W;
  localparam int FMUL_W = 32;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_PROMOTE = 10'b00_0000_0010,
    ST_CHK1    = 10'b00_0000_0100,
    ST_FRAC    = 10'b00_0000_1000,
    ST_BLEND   = 10'b00_0001_0000,
    ST_ADV     = 10'b00_0010_0000,
    ST_PLACE   = 10'b00_0100_0000,
    ST_CHK2    = 10'b00_1000_0000,
    ST_FINAL   = 10'b01_0000_0000,
    ST_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  state_t              ret_r, ret_nxt;
  logic [SAMPLE_W-1:0] x_r, x_nxt;
  logic                fin_r, fin_nxt;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                have_r, have_nxt;
  logic [RATE_W-1:0]   rem_r, rem_nxt;
  logic [POS_W-1:0]    ops_r, ops_nxt;
  logic [POS_W-1:0]    ips_r, ips_nxt;
  logic [POS_W-1:0]    k_r, k_nxt;
  logic [POS_W-1:0]    left_r, left_nxt;
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic                held_v_r, held_v_nxt;
  logic [SAMPLE_W-1:0] pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic [SAMPLE_W-1:0] val_r, val_nxt;
  logic [GUARD_W-1:0]  guard_r, guard_nxt;
  logic                phase_r, phase_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SAMPLE_W-1:0] emit_data_r, emit_data_nxt;
  logic                emit_last_r, emit_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;
  logic                clear;
  state_t              place_next;

  logic signed [SAMPLE_W:0] diff;
  logic signed [FMUL_W:0]   frac_s;
  logic signed [PROD_W-1:0] prod_full;
  logic [PROD_W-1:0]        prod_rnd;
  logic [STEP_W-1:0]        blend_sum;

  function automatic logic pos_reached(input logic [POS_W-1:0] pos,
                                       input logic [RATE_W-1:0] rem,
                                       input logic [POS_W-1:0] n);
    pos_reached = (pos < n) || ((pos == n) && (rem == '0));
  endfunction

  // blend: left + round-half-up((right - left) * frac / 2^16)
  // a remainder left over from older rates can give frac above 2^16; only the low
  // product bits reach the sample, so the low 32 fraction bits are enough
  assign diff      = $signed({x_r[SAMPLE_W-1], x_r}) - $signed({prev_r[SAMPLE_W-1], prev_r});
  assign frac_s    = $signed({1'b0, div_rsp.quot[FMUL_W-1:0]});
  assign prod_full = PROD_W'(diff) * PROD_W'(frac_s);
  assign prod_rnd  = prod_r + ROUND_HALF;
  assign blend_sum = prod_rnd[PROD_W-1:FRAC_W]
                   + {{(STEP_W - SAMPLE_W){prev_r[SAMPLE_W-1]}}, prev_r};

  assign place_next = phase_r ? ST_CHK2 : ST_CHK1;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    x_nxt         = x_r;
    fin_nxt       = fin_r;
    prev_nxt      = prev_r;
    have_nxt      = have_r;
    rem_nxt       = rem_r;
    ops_nxt       = ops_r;
    ips_nxt       = ips_r;
    k_nxt         = k_r;
    left_nxt      = left_r;
    held_nxt      = held_r;
    held_v_nxt    = held_v_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    val_nxt       = val_r;
    guard_nxt     = guard_r;
    phase_nxt     = phase_r;
    prod_nxt      = prod_r;
    emit_data_nxt = emit_data_r;
    emit_last_nxt = emit_last_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    clear         = 1'b0;
    q_pop         = 1'b0;
    div_req       = '0;
    div_req.divisor = rates.dst;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          x_nxt   = q_item.sample;
          fin_nxt = q_item.fin;
          if (q_item.pass) begin
            clear         = 1'b1;
            emit_data_nxt = q_item.sample;
            emit_last_nxt = q_item.fin;
            ret_nxt       = ST_IDLE;
            state_nxt     = ST_EMIT;
          end else begin
            k_nxt     = ips_r;
            left_nxt  = ips_r - POS_W'(1);
            ips_nxt   = ips_r + POS_W'(1);
            state_nxt = ST_PROMOTE;
          end
        end
      end

      ST_PROMOTE: begin
        guard_nxt = '0;
        phase_nxt = 1'b0;
        state_nxt = ST_CHK1;
        if (pend_v_r && pos_reached(ops_r, rem_r, ips_r)) begin
          pend_v_nxt = 1'b0;
          held_nxt   = pend_r;
          held_v_nxt = 1'b1;
          if (held_v_r) begin
            emit_data_nxt = held_r;
            emit_last_nxt = 1'b0;
            ret_nxt       = ST_CHK1;
            state_nxt     = ST_EMIT;
          end
        end
      end

      ST_CHK1: begin
        if (have_r && (ops_r == left_r) && (guard_r < GUARD_W'(GUARD_MAX))) begin
          // remainder followed by 16 zero bits, divided by the target rate
          div_req.start    = 1'b1;
          div_req.init_rem = '0;
          div_req.numer    = DIVN_W'(rem_r);
          div_req.steps    = DIVC_W'(DIVQ_W);
          state_nxt        = ST_FRAC;
        end else begin
          guard_nxt = '0;
          phase_nxt = 1'b1;
          state_nxt = ST_CHK2;
        end
      end

      ST_FRAC: begin
        if (div_rsp.done) begin
          prod_nxt  = prod_full;
          state_nxt = ST_BLEND;
        end
      end

      ST_BLEND: begin
        val_nxt          = blend_sum[SAMPLE_W-1:0];
        div_req.start    = 1'b1;
        div_req.init_rem = '0;
        div_req.numer    = DIVN_W'(rem_r) + DIVN_W'(rates.src);
        div_req.steps    = DIVC_W'(DIVN_W);
        state_nxt        = ST_ADV;
      end

      ST_ADV: begin
        if (div_rsp.done) begin
          ops_nxt   = ops_r + POS_W'(div_rsp.quot);
          rem_nxt   = div_rsp.rem;
          guard_nxt = guard_r + GUARD_W'(1);
          state_nxt = ST_PLACE;
        end
      end

      ST_PLACE: begin
        state_nxt = place_next;
        if (pos_reached(ops_r, rem_r, ips_r)) begin
          held_nxt   = val_r;
          held_v_nxt = 1'b1;
          if (held_v_r) begin
            emit_data_nxt = held_r;
            emit_last_nxt = 1'b0;
            ret_nxt       = place_next;
            state_nxt     = ST_EMIT;
          end
        end else begin
          pend_nxt   = val_r;
          pend_v_nxt = 1'b1;
        end
      end

      ST_CHK2: begin
        if (fin_r && (ops_r == k_r) && (guard_r < GUARD_W'(GUARD_MAX))) begin
          val_nxt          = x_r;
          div_req.start    = 1'b1;
          div_req.init_rem = '0;
          div_req.numer    = DIVN_W'(rem_r) + DIVN_W'(rates.src);
          div_req.steps    = DIVC_W'(DIVN_W);
          state_nxt        = ST_ADV;
        end else if (fin_r) begin
          state_nxt = ST_FINAL;
        end else begin
          prev_nxt  = x_r;
          have_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_FINAL: begin
        clear     = 1'b1;
        state_nxt = ST_IDLE;
        if (pend_v_r && !held_v_r) begin
          emit_data_nxt = pend_r;
          emit_last_nxt = 1'b1;
          ret_nxt       = ST_IDLE;
          state_nxt     = ST_EMIT;
        end else if (held_v_r) begin
          emit_data_nxt = held_r;
          emit_last_nxt = 1'b1;
          ret_nxt       = ST_IDLE;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = emit_data_r;
          out_last_nxt  = emit_last_r;
          state_nxt     = ret_r;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // stream end or passthrough: back to the reset stream state
    if (clear) begin
      prev_nxt   = '0;
      have_nxt   = 1'b0;
      rem_nxt    = '0;
      ops_nxt    = '0;
      ips_nxt    = '0;
      held_nxt   = '0;
      held_v_nxt = 1'b0;
      pend_nxt   = '0;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      prev_r      <= '0;
      have_r      <= 1'b0;
      rem_r       <= '0;
      ops_r       <= '0;
      ips_r       <= '0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      pend_r      <= '0;
      pend_v_r    <= 1'b0;
      guard_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      prev_r      <= prev_nxt;
      have_r      <= have_nxt;
      rem_r       <= rem_nxt;
      ops_r       <= ops_nxt;
      ips_r       <= ips_nxt;
      held_r      <= held_nxt;
      held_v_r    <= held_v_nxt;
      pend_r      <= pend_nxt;
      pend_v_r    <= pend_v_nxt;
      guard_r     <= guard_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    fin_r       <= fin_nxt;
    k_r         <= k_nxt;
    left_r      <= left_nxt;
    val_r       <= val_nxt;
    prod_r      <= prod_nxt;
    emit_data_r <= emit_data_nxt;
    emit_last_r <= emit_last_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign out_last      = out_last_r;
  assign stat.div_wait = (state_r == ST_FRAC) || (state_r == ST_ADV);
  assign stat.guard    = guard_r;

endmodule

`default_nettype wire
